/* rtl/core/gjls_pkg.sv */
package gjls_pkg;

  localparam int unsigned MaxSize  = 8;
  localparam int unsigned FracBits = 16;
  localparam int unsigned RowReach = 8;

  typedef enum logic [1:0] {
    CmdWriteA   = 2'd0,
    CmdWriteB   = 2'd1,
    CmdSolve    = 2'd2,
    CmdReserved = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    StIdle,
    StCopy,
    StPivRd,
    StPivWait,
    StPivChk,
    StElimRd,
    StElimWait,
    StElimDiv,
    StRowRd,
    StRowWait,
    StRowMul,
    StRowWr,
    StRecipDiv,
    StScaleRd,
    StScaleWait,
    StScaleMul,
    StScaleWr,
    StOutRd,
    StOutWait,
    StOutMul,
    StOutAcc,
    StOutEmit
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    return sat32(s);
  endfunction

endpackage

/* rtl/core/gjls_div.sv */
module gjls_div #(
  parameter int unsigned FracBits = gjls_pkg::FracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gjls_pkg::div_ctrl_t ctrl_i,
  input  logic signed [31:0]  num_i,
  input  logic signed [31:0]  den_i,
  output logic                done_o,
  output logic signed [31:0]  quo_o
);

  localparam int unsigned NumW = 32 + FracBits + 1;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] an_q, an_d;
  logic [32:0]     am_q, am_d;
  logic [NumW-1:0] q_q, q_d;
  logic [NumW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic signed [31:0] quo_q, quo_d;

  logic [NumW-1:0]         an_start;
  logic [32:0]             am_start;
  logic signed [NumW:0]    n_full;
  logic [NumW:0]           trial;
  logic [NumW:0]           shifted;
  logic signed [NumW+1:0]  qs;

  always_comb begin
    n_full   = (NumW+1)'(num_i) <<< FracBits;
    an_start = n_full[NumW] ? NumW'(-n_full) : NumW'(n_full);
    am_start = den_i[31] ? 33'(-34'(den_i)) : 33'(den_i);
    shifted  = {rem_q[NumW-1:0], an_q[NumW-1]};
    trial    = shifted - (NumW+1)'(am_q);
  end

  always_comb begin
    an_d   = an_q;
    am_d   = am_q;
    q_d    = q_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    qs     = '0;
    if (ctrl_i.start) begin
      an_d  = an_start + NumW'(am_start >> 1);
      am_d  = am_start;
      q_d   = '0;
      rem_d = '0;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
      neg_d = num_i[31] ^ den_i[31];
    end else if (run_q) begin
      an_d = an_q << 1;
      if (!trial[NumW]) begin
        rem_d = trial;
        q_d   = {q_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        q_d   = {q_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        qs     = neg_q ? -(NumW+2)'(q_d) : (NumW+2)'(q_d);
        quo_d  = gjls_pkg::sat32(66'(qs));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q  <= an_d;
    am_q  <= am_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

`ifndef ASSERT_OFF
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q)) else $error("divider done without run");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !ctrl_i.start |=> run_q || done_q) else $error("divider dropped");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
`endif

endmodule

/* rtl/core/gauss_jordan_linear_solver_core.sv */
// Gauss-Jordan solver: load A with cmd 0 and B with cmd 1, one load transaction
// per cycle while idle, then cmd 2 solves for the size in size_q (clamped to 1..8)
// and emits n results of X = inv(A)*B, last marked, singular set on any zero
// pivot. A solve is paced by result stalls, by a read, wait, multiply, write
// pass per entry on the work and inverse memories and by a bit-serial divider
// that holds the sequence on each of the n*n divisions.
module gauss_jordan_linear_solver_core #(
  parameter int unsigned MaxSize  = gjls_pkg::MaxSize,
  parameter int unsigned FracBits = gjls_pkg::FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], row[4:2], col[7:5], value[39:8]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // index[2:0], x_value[34:3], zero fill
  output logic [39:0] m_axis_tdata,
  // singular
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned IdxW  = (MaxSize > 1) ? $clog2(MaxSize) : 1;
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned Reach = (MaxSize < gjls_pkg::RowReach) ?
                                  MaxSize : gjls_pkg::RowReach;
  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  gjls_pkg::state_e state_q, state_d;

  logic [3:0] size_q;
  logic [IdxW-1:0] n_last_q, n_last_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic sing_q, sing_d;
  logic elim_end;

  logic signed [31:0] a_mem [Depth];
  logic signed [31:0] w_mem [Depth];
  logic signed [31:0] v_mem [Depth];
  logic signed [31:0] b_mem [MaxSize];
  logic [Depth-1:0]   a_vld_q;
  logic [MaxSize-1:0] b_vld_q;

  logic [AddrW-1:0] rd_addr, rd2_addr, wr_addr;
  logic             w_we, v_we, copy_we;
  logic signed [31:0] w_wdata, v_wdata;
  logic signed [31:0] w_rd_q, v_rd_q, w_rd2_q, v_rd2_q, a_rd_q, b_rd_q;
  logic               a_rdv_q, b_rdv_q;

  logic signed [31:0] piv_q, piv_d, s_q, s_d, acc_q, acc_d;
  logic signed [31:0] pw_q, pv_q, pw_d, pv_d;

  gjls_pkg::div_ctrl_t div_ctrl;
  logic signed [31:0]  div_num, div_den, div_quo;
  logic                div_done;

  logic signed [31:0] mul_a0, mul_b0, mul_a1, mul_b1;
  logic signed [63:0] prod0_q, prod1_q;
  logic signed [31:0] mr0, mr1;

  logic        out_vld_q, out_vld_d;
  logic [39:0] out_data_q, out_data_d;
  logic        out_sing_q, out_last_q, out_sing_d, out_last_d;

  logic        in_fire;
  gjls_pkg::cmd_e in_cmd;
  logic [2:0]  in_row, in_col;
  logic signed [31:0] in_val;
  logic        row_ok, col_ok;

  assign in_cmd  = gjls_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign in_row  = s_axis_tdata[4:2];
  assign in_col  = s_axis_tdata[7:5];
  assign in_val  = s_axis_tdata[39:8];
  assign row_ok  = 32'(in_row) < MaxSize;
  assign col_ok  = 32'(in_col) < MaxSize;
  assign s_axis_tready = (state_q == gjls_pkg::StIdle);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign elim_end = (k_q == n_last_q) &&
                    (j_q == n_last_q || (j_q + 1'b1 == i_q && i_q == n_last_q));

  function automatic logic signed [31:0] fx_round(input logic signed [63:0] p);
    logic signed [65:0] t;
    t = (66'(p) + (66'sd1 <<< (FracBits - 1))) >>> FracBits;
    return gjls_pkg::sat32(t);
  endfunction

  assign mr0 = fx_round(prod0_q);
  assign mr1 = fx_round(prod1_q);

  always_ff @(posedge clk_i) begin
    prod0_q <= mul_a0 * mul_b0;
    prod1_q <= mul_a1 * mul_b1;
  end

  gjls_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .ctrl_i(div_ctrl), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'd8;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    n_last_d = n_last_q;
    if (size_q == 4'd0) begin
      n_last_d = '0;
    end else if (32'(size_q) > Reach) begin
      n_last_d = IdxW'(Reach - 1);
    end else begin
      n_last_d = IdxW'(size_q - 4'd1);
    end
  end

  // a and b stores with valid bits for the cleared reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= '0;
      b_vld_q <= '0;
    end else if (in_fire) begin
      if (in_cmd == gjls_pkg::CmdWriteA && row_ok && col_ok) begin
        a_vld_q[{IdxW'(in_row), IdxW'(in_col)}] <= 1'b1;
      end
      if (in_cmd == gjls_pkg::CmdWriteB && row_ok) begin
        b_vld_q[IdxW'(in_row)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_cmd == gjls_pkg::CmdWriteA && row_ok && col_ok) begin
      a_mem[{IdxW'(in_row), IdxW'(in_col)}] <= in_val;
    end
    if (in_fire && in_cmd == gjls_pkg::CmdWriteB && row_ok) begin
      b_mem[IdxW'(in_row)] <= in_val;
    end
    a_rd_q  <= a_mem[rd_addr];
    a_rdv_q <= a_vld_q[rd_addr];
    b_rd_q  <= b_mem[k_q];
    b_rdv_q <= b_vld_q[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[wr_addr] <= w_wdata;
    if (v_we) v_mem[wr_addr] <= v_wdata;
    w_rd_q  <= w_mem[rd_addr];
    v_rd_q  <= v_mem[rd_addr];
    w_rd2_q <= w_mem[rd2_addr];
    v_rd2_q <= v_mem[rd2_addr];
  end

  // copy pipeline: a read issued in StCopy lands in the next cycle
  logic            cp_vld_q;
  logic [AddrW-1:0] cp_addr_q;
  logic            cp_diag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_vld_q <= 1'b0;
    end else begin
      cp_vld_q <= (state_q == gjls_pkg::StCopy);
    end
  end
  always_ff @(posedge clk_i) begin
    cp_addr_q <= {j_q, k_q};
    cp_diag_q <= (j_q == k_q);
  end
  assign copy_we = cp_vld_q;

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    sing_d = sing_q;
    piv_d = piv_q; s_d = s_q; acc_d = acc_q;
    pw_d = pw_q; pv_d = pv_q;
    unique case (state_q)
      gjls_pkg::StIdle: begin
        if (in_fire && in_cmd == gjls_pkg::CmdSolve) begin
          state_d = gjls_pkg::StCopy;
          j_d = '0; k_d = '0; i_d = '0;
          sing_d = 1'b0;
        end
      end
      gjls_pkg::StCopy: begin
        if (k_q == n_last_q) begin
          k_d = '0;
          if (j_q == n_last_q) begin
            state_d = gjls_pkg::StPivRd;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      gjls_pkg::StPivRd: state_d = copy_we ? gjls_pkg::StPivRd : gjls_pkg::StPivWait;
      gjls_pkg::StPivWait: begin
        piv_d = w_rd_q;
        state_d = gjls_pkg::StPivChk;
      end
      gjls_pkg::StPivChk: begin
        j_d = '0;
        if (piv_q == '0) begin
          sing_d = 1'b1;
          if (i_q == n_last_q) begin
            state_d = gjls_pkg::StOutRd;
            i_d = '0; k_d = '0;
          end else begin
            i_d = i_q + 1'b1;
            state_d = gjls_pkg::StPivRd;
          end
        end else if (i_q == '0) begin
          j_d = (n_last_q == '0) ? '0 : IdxW'(1);
          state_d = (n_last_q == '0) ? gjls_pkg::StRecipDiv : gjls_pkg::StElimRd;
        end else begin
          state_d = gjls_pkg::StElimRd;
        end
      end
      gjls_pkg::StElimRd: state_d = gjls_pkg::StElimWait;
      gjls_pkg::StElimWait: state_d = gjls_pkg::StElimDiv;
      gjls_pkg::StElimDiv: begin
        if (div_done) begin
          s_d = (div_quo == 32'sh80000000) ? 32'sh7fffffff : -div_quo;
          k_d = '0;
          state_d = gjls_pkg::StRowRd;
        end
      end
      gjls_pkg::StRowRd: state_d = gjls_pkg::StRowWait;
      gjls_pkg::StRowWait: begin
        pw_d = w_rd_q; pv_d = v_rd_q;
        state_d = gjls_pkg::StRowMul;
      end
      gjls_pkg::StRowMul: state_d = gjls_pkg::StRowWr;
      gjls_pkg::StRowWr: begin
        if (k_q == n_last_q) begin
          if (j_q == n_last_q || (j_q + 1'b1 == i_q && i_q == n_last_q)) begin
            state_d = gjls_pkg::StRecipDiv;
          end else begin
            j_d = (j_q + 1'b1 == i_q) ? j_q + 2'd2 : j_q + 1'b1;
            state_d = gjls_pkg::StElimRd;
          end
        end else begin
          k_d = k_q + 1'b1;
          state_d = gjls_pkg::StRowRd;
        end
      end
      gjls_pkg::StRecipDiv: begin
        if (div_done) begin
          s_d = div_quo;
          k_d = '0;
          state_d = gjls_pkg::StScaleRd;
        end
      end
      gjls_pkg::StScaleRd: state_d = gjls_pkg::StScaleWait;
      gjls_pkg::StScaleWait: begin
        pw_d = w_rd_q; pv_d = v_rd_q;
        state_d = gjls_pkg::StScaleMul;
      end
      gjls_pkg::StScaleMul: state_d = gjls_pkg::StScaleWr;
      gjls_pkg::StScaleWr: begin
        if (k_q == n_last_q) begin
          if (i_q == n_last_q) begin
            state_d = gjls_pkg::StOutRd;
            i_d = '0; k_d = '0; acc_d = '0;
          end else begin
            i_d = i_q + 1'b1;
            state_d = gjls_pkg::StPivRd;
          end
        end else begin
          k_d = k_q + 1'b1;
          state_d = gjls_pkg::StScaleRd;
        end
      end
      gjls_pkg::StOutRd: begin
        if (k_q == '0) acc_d = '0;
        state_d = gjls_pkg::StOutWait;
      end
      gjls_pkg::StOutWait: begin
        pv_d = v_rd_q;
        s_d  = b_rdv_q ? b_rd_q : '0;
        state_d = gjls_pkg::StOutMul;
      end
      gjls_pkg::StOutMul: state_d = gjls_pkg::StOutAcc;
      gjls_pkg::StOutAcc: begin
        acc_d = gjls_pkg::fx_add(acc_q, mr1);
        if (k_q == n_last_q) begin
          state_d = gjls_pkg::StOutEmit;
        end else begin
          k_d = k_q + 1'b1;
          state_d = gjls_pkg::StOutRd;
        end
      end
      gjls_pkg::StOutEmit: begin
        if (!out_vld_q) begin
          k_d = '0;
          if (i_q == n_last_q) begin
            state_d = gjls_pkg::StIdle;
          end else begin
            i_d = i_q + 1'b1;
            state_d = gjls_pkg::StOutRd;
          end
        end
      end
      default: state_d = gjls_pkg::StIdle;
    endcase
  end

  // piv row i j-loop: first j skips i when i is 0
  always_comb begin
    rd_addr  = {i_q, i_q};
    rd2_addr = {j_q, k_q};
    wr_addr  = {j_q, k_q};
    w_we = 1'b0; v_we = 1'b0;
    w_wdata = '0; v_wdata = '0;
    div_ctrl = '0;
    div_num = One; div_den = piv_q;
    mul_a0 = pw_q; mul_b0 = s_q;
    mul_a1 = pv_q; mul_b1 = s_q;
    out_vld_d = out_vld_q;
    out_data_d = out_data_q;
    out_sing_d = out_sing_q;
    out_last_d = out_last_q;
    if (out_vld_q && m_axis_tready) out_vld_d = 1'b0;
    unique case (state_q)
      gjls_pkg::StCopy: rd_addr = {j_q, k_q};
      gjls_pkg::StPivRd: rd_addr = {i_q, i_q};
      gjls_pkg::StElimRd: rd_addr = {j_q, i_q};
      gjls_pkg::StElimWait: begin
        div_ctrl.start = 1'b1;
        div_num = w_rd_q;
      end
      gjls_pkg::StRowRd: begin
        rd_addr  = {i_q, k_q};
        rd2_addr = {j_q, k_q};
      end
      gjls_pkg::StRowWr: begin
        w_we = 1'b1; v_we = 1'b1;
        w_wdata = gjls_pkg::fx_add(w_rd2_q, mr0);
        v_wdata = gjls_pkg::fx_add(v_rd2_q, mr1);
        div_ctrl.start = elim_end;
      end
      gjls_pkg::StPivChk: begin
        div_ctrl.start = (piv_q != '0);
      end
      gjls_pkg::StScaleRd: rd_addr = {i_q, k_q};
      gjls_pkg::StScaleWr: begin
        wr_addr = {i_q, k_q};
        w_we = 1'b1; v_we = 1'b1;
        w_wdata = mr0; v_wdata = mr1;
      end
      gjls_pkg::StOutRd: rd_addr = {i_q, k_q};
      gjls_pkg::StOutEmit: begin
        if (!out_vld_q) begin
          out_vld_d = 1'b1;
          out_data_d = {5'd0, acc_q, 3'(i_q)};
          out_sing_d = sing_q;
          out_last_d = (i_q == n_last_q);
        end
      end
      default: ;
    endcase
    if (copy_we) begin
      wr_addr = cp_addr_q;
      w_we = 1'b1; v_we = 1'b1;
      w_wdata = a_rdv_q ? a_rd_q : '0;
      v_wdata = cp_diag_q ? One : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gjls_pkg::StIdle;
      out_vld_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0;
      sing_q <= 1'b0;
      n_last_q <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d;
      sing_q <= sing_d;
      n_last_q <= (state_q == gjls_pkg::StIdle) ? n_last_d : n_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    piv_q <= piv_d; s_q <= s_d; acc_q <= acc_d;
    pw_q <= pw_d; pv_q <= pv_d;
    out_data_q <= out_data_d;
    out_sing_q <= out_sing_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sing_q;
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == gjls_pkg::StIdle) else $error("accept while busy");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gjls_pkg::StOutEmit && !out_vld_q |=> out_vld_q)
    else $error("result lost");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gjls_pkg::StRecipDiv && $past(state_q) != gjls_pkg::StRecipDiv
    |-> $past(div_ctrl.start)) else $error("divider not started");
`endif

endmodule
